@@ src/c6502g2_pkg.sv @@
`default_nettype none

package c6502g2_pkg;

    // Operation row, opcode bits 7:5
    typedef enum logic [2:0] {
        ROW_ASL = 3'd0,
        ROW_ROL = 3'd1,
        ROW_LSR = 3'd2,
        ROW_ROR = 3'd3,
        ROW_STX = 3'd4,
        ROW_LDX = 3'd5,
        ROW_DEC = 3'd6,
        ROW_INC = 3'd7
    } row_t;

    // Addressing column, opcode bits 4:2
    typedef enum logic [2:0] {
        COL_IMM  = 3'd0,
        COL_ZP   = 3'd1,
        COL_ACC  = 3'd2,
        COL_ABS  = 3'd3,
        COL_JAM  = 3'd4,
        COL_ZPI  = 3'd5,
        COL_IMP  = 3'd6,
        COL_ABSI = 3'd7
    } col_t;

    typedef struct packed {
        logic [7:0] opcode;
        logic [7:0] mem_data;
        logic [7:0] addr_high;
        logic       page_crossed;
    } in_item_t;

    typedef struct packed {
        logic       write_enable;
        logic [7:0] write_data;
        logic [2:0] cycle_count;
        logic       halted;
        logic [7:0] acc_value;
        logic [7:0] xreg_value;
        logic [7:0] stack_value;
        logic       carry_flag;
        logic       zero_flag;
        logic       negative_flag;
    } out_item_t;

    // Architectural state kept between instructions
    typedef struct packed {
        logic [7:0] acc;
        logic [7:0] xr;
        logic [7:0] sp;
        logic       c;
        logic       z;
        logic       n;
    } arch_state_t;

endpackage

`default_nettype wire

@@ src/c6502g2_stream_if.sv @@
`default_nettype none

interface c6502g2_stream_if #(
    parameter type payload_t = logic
);
    logic     valid;
    logic     ready;
    payload_t payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

`default_nettype wire

@@ src/c6502g2_exec.sv @@
`default_nettype none

module c6502g2_exec
    import c6502g2_pkg::*;
(
    input  in_item_t    item,
    input  arch_state_t st,
    output arch_state_t st_next,
    output out_item_t   result
);

    // Shift or rotate by row; returns {carry_out, byte}
    function automatic logic [8:0] shift_op(input row_t row, input logic [7:0] v,
                                            input logic oc);
        logic [8:0] r;
        begin
            case (row)
                ROW_ASL: r = {v[7], v[6:0], 1'b0};
                ROW_ROL: r = {v[7], v[6:0], oc};
                ROW_LSR: r = {v[0], 1'b0, v[7:1]};
                ROW_ROR: r = {v[0], oc, v[7:1]};
                default: r = {oc, v};
            endcase
            return r;
        end
    endfunction

    row_t       row;
    col_t       col;
    logic       xy;
    logic [8:0] sh_acc;
    logic [8:0] sh_mem;
    logic [7:0] mem_dec;
    logic [7:0] mem_inc;
    logic [7:0] shx_mask;
    logic       we;
    logic [7:0] wd;
    logic [2:0] cyc;
    logic       halt;

    assign row      = row_t'(item.opcode[7:5]);
    assign col      = col_t'(item.opcode[4:2]);
    assign xy       = (row == ROW_STX) || (row == ROW_LDX);
    assign sh_acc   = shift_op(row, st.acc, st.c);
    assign sh_mem   = shift_op(row, item.mem_data, st.c);
    assign mem_dec  = item.mem_data - 8'd1;
    assign mem_inc  = item.mem_data + 8'd1;
    assign shx_mask = item.addr_high + 8'd1;

    always_comb
    begin
        st_next = st;
        we      = 1'b0;
        wd      = 8'd0;
        cyc     = 3'd2;
        halt    = 1'b0;
        case (col)
            COL_JAM:
            begin
                halt = 1'b1;
                cyc  = 3'd3;
            end
            COL_IMM:
            begin
                if (!row[2])
                begin
                    halt = 1'b1;
                    cyc  = 3'd3;
                end
                else if (row == ROW_LDX)
                begin
                    st_next.xr = item.mem_data;
                    st_next.z  = (item.mem_data == 8'd0);
                    st_next.n  = item.mem_data[7];
                end
            end
            COL_ACC:
            begin
                case (row)
                    ROW_ASL, ROW_ROL, ROW_LSR, ROW_ROR:
                    begin
                        st_next.c   = sh_acc[8];
                        st_next.acc = sh_acc[7:0];
                        st_next.z   = (sh_acc[7:0] == 8'd0);
                        st_next.n   = sh_acc[7];
                    end
                    ROW_STX:
                    begin
                        st_next.acc = st.xr;
                        st_next.z   = (st.xr == 8'd0);
                        st_next.n   = st.xr[7];
                    end
                    ROW_LDX:
                    begin
                        st_next.xr = st.acc;
                        st_next.z  = (st.acc == 8'd0);
                        st_next.n  = st.acc[7];
                    end
                    ROW_DEC:
                    begin
                        st_next.xr = st.xr - 8'd1;
                        st_next.z  = (st.xr == 8'd1);
                        st_next.n  = st_next.xr[7];
                    end
                    default: ;
                endcase
            end
            COL_IMP:
            begin
                if (row == ROW_STX)
                begin
                    st_next.sp = st.xr;
                end
                else if (row == ROW_LDX)
                begin
                    st_next.xr = st.sp;
                    st_next.z  = (st.sp == 8'd0);
                    st_next.n  = st.sp[7];
                end
            end
            default:
            begin
                // memory columns: zp, abs, zp indexed, abs indexed
                case (col)
                    COL_ZP:  cyc = xy ? 3'd3 : 3'd5;
                    COL_ABS: cyc = xy ? 3'd4 : 3'd6;
                    COL_ZPI: cyc = xy ? 3'd4 : 3'd6;
                    default: cyc = xy ? (3'd4 + {2'b00, item.page_crossed}) : 3'd7;
                endcase
                case (row)
                    ROW_STX:
                    begin
                        we = 1'b1;
                        wd = (col == COL_ABSI) ? (st.xr & shx_mask) : st.xr;
                    end
                    ROW_LDX:
                    begin
                        st_next.xr = item.mem_data;
                        st_next.z  = (item.mem_data == 8'd0);
                        st_next.n  = item.mem_data[7];
                    end
                    ROW_DEC:
                    begin
                        we        = 1'b1;
                        wd        = mem_dec;
                        st_next.z = (mem_dec == 8'd0);
                        st_next.n = mem_dec[7];
                    end
                    ROW_INC:
                    begin
                        we        = 1'b1;
                        wd        = mem_inc;
                        st_next.z = (mem_inc == 8'd0);
                        st_next.n = mem_inc[7];
                    end
                    default:
                    begin
                        we        = 1'b1;
                        wd        = sh_mem[7:0];
                        st_next.c = sh_mem[8];
                        st_next.z = (sh_mem[7:0] == 8'd0);
                        st_next.n = sh_mem[7];
                    end
                endcase
            end
        endcase
    end

    always_comb
    begin
        result.write_enable  = we;
        result.write_data    = wd;
        result.cycle_count   = cyc;
        result.halted        = halt;
        result.acc_value     = st_next.acc;
        result.xreg_value    = st_next.xr;
        result.stack_value   = st_next.sp;
        result.carry_flag    = st_next.c;
        result.zero_flag     = st_next.z;
        result.negative_flag = st_next.n;
    end

endmodule

`default_nettype wire

@@ src/cpu6502_group2_execute_top.sv @@
// Each accepted beat passes the input register, then the result register, to the output.
// Throughput: one instruction per cycle unless the output stalls. The execute logic reads
// and updates A, X, SP and C/Z/N in the same cycle it loads the result register.
// Reset (rst_n low, asynchronous): both stages empty, A, X, SP and all flags cleared.
`default_nettype none

module cpu6502_group2_execute_top
    import c6502g2_pkg::*;
(
    input  wire logic      clk,
    input  wire logic      rst_n,
    c6502g2_stream_if.sink   in_ch,
    c6502g2_stream_if.source out_ch
);

    // Input stage: holds one accepted beat until it executes
    in_item_t    in_reg;
    logic        in_valid_reg;

    // Architectural state
    arch_state_t st_reg;
    arch_state_t st_next;

    // Result stage
    out_item_t   out_reg;
    logic        out_valid_reg;

    out_item_t   result;
    logic        exec_fire;
    logic        in_fire;

    // Execute whenever the result register is free or being drained this cycle.
    assign exec_fire   = in_valid_reg && (!out_valid_reg || out_ch.ready);
    // Take a new beat whenever the input register is empty or advancing.
    assign in_ch.ready = !in_valid_reg || exec_fire;
    assign in_fire     = in_ch.valid && in_ch.ready;

    assign out_ch.valid   = out_valid_reg;
    assign out_ch.payload = out_reg;

    c6502g2_exec u_exec (
        .item    (in_reg),
        .st      (st_reg),
        .st_next (st_next),
        .result  (result)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            st_reg        <= '0;
        end
        else
        begin
            if (in_ch.ready)
            begin
                in_valid_reg <= in_ch.valid;
            end
            if (exec_fire)
            begin
                out_valid_reg <= 1'b1;
                st_reg        <= st_next;
            end
            else if (out_ch.ready)
            begin
                // drop the delivered result
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Payload registers: no reset needed
    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            in_reg <= in_ch.payload;
        end
        if (exec_fire)
        begin
            out_reg <= result;
        end
    end

    // An executed instruction always presents a result in the next cycle.
    assert property (@(posedge clk) disable iff (!rst_n)
        exec_fire |=> out_valid_reg)
        else $error("executed beat did not reach the result register");

    // Jam opcodes leave the architectural state untouched.
    assert property (@(posedge clk) disable iff (!rst_n)
        exec_fire && result.halted |=> st_reg == $past(st_reg))
        else $error("jam opcode changed architectural state");

    // State changes only when an instruction executes.
    assert property (@(posedge clk) disable iff (!rst_n)
        !exec_fire |=> $stable(st_reg))
        else $error("state changed without an executing instruction");

    // A held input beat blocks new beats.
    assert property (@(posedge clk) disable iff (!rst_n)
        in_valid_reg && !exec_fire |-> !in_ch.ready)
        else $error("input accepted while stage is stalled");

    // No write data without a write.
    assert property (@(posedge clk) disable iff (!rst_n)
        exec_fire && !result.write_enable |-> result.write_data == 8'd0)
        else $error("write data present without write enable");

endmodule

`default_nettype wire

@@ sim/testbench.sv @@
`timescale 1ns / 1ps

module testbench;
    import c6502g2_pkg::*;

    // Low opcode bits that select this instruction group
    localparam logic [1:0] GROUP2_LOW = 2'b10;
    // Length of the output hold-off, long enough to fill every stage
    localparam int HOLD_OFF = 40;
    // Keep the log short if the block is badly broken
    localparam int MAX_REPORTS = 40;

    logic clk = 1'b0;
    logic rst_n;

    c6502g2_stream_if #(.payload_t(in_item_t))  in_ch ();
    c6502g2_stream_if #(.payload_t(out_item_t)) out_ch ();

    cpu6502_group2_execute_top DUT (
        .clk    (clk),
        .rst_n  (rst_n),
        .in_ch  (in_ch),
        .out_ch (out_ch)
    );

    // Toggle the clock every half period
    always #5 clk = ~clk;

    // Predicted A, X, SP and flags, as of the last accepted instruction
    arch_state_t cpu_state;
    // Results still owed by the block, oldest first
    out_item_t   expected_results[$];

    bit src_idle;          // sender inserts random gaps between beats
    bit snk_idle;          // receiver drops ready at random between beats
    int hold_off_cycles;   // nonzero asks the receiver for one long hold-off

    int mismatch_count;
    int instr_sent;
    int results_checked;
    int jam_results;
    int write_results;

    // ------------------------------------------------------------------
    // Predictor
    // ------------------------------------------------------------------

    // Update Z and N from a result byte
    function automatic void update_zn(input logic [7:0] v);
        cpu_state.z = (v == 8'h00);
        cpu_state.n = v[7];
    endfunction

    // ASL, ROL, LSR, ROR on one byte; update C, Z, N
    function automatic logic [7:0] shift_byte(input row_t row, input logic [7:0] v);
        logic       old_c;
        logic [7:0] r;
        old_c = cpu_state.c;
        case (row)
            ROW_ASL:
            begin
                cpu_state.c = v[7];
                r = {v[6:0], 1'b0};
            end
            ROW_ROL:
            begin
                cpu_state.c = v[7];
                r = {v[6:0], old_c};
            end
            ROW_LSR:
            begin
                cpu_state.c = v[0];
                r = {1'b0, v[7:1]};
            end
            default:
            begin
                cpu_state.c = v[0];
                r = {old_c, v[7:1]};
            end
        endcase
        update_zn(r);
        return r;
    endfunction

    // Execute one instruction against cpu_state and return the result it should give
    function automatic out_item_t execute_group2(input in_item_t it);
        out_item_t  r;
        col_t       col;
        row_t       row;
        logic       x_or_y_row;
        logic [7:0] d;
        col = col_t'(it.opcode[4:2]);
        row = row_t'(it.opcode[7:5]);
        x_or_y_row = (row == ROW_STX) || (row == ROW_LDX);
        r = '0;
        r.cycle_count = 3'd2;

        if (col == COL_JAM || (col == COL_IMM && row < ROW_STX))
        begin
            r.halted = 1'b1;
            r.cycle_count = 3'd3;
        end
        else if (col == COL_IMM)
        begin
            if (row == ROW_LDX)
            begin
                cpu_state.xr = it.mem_data;
                update_zn(cpu_state.xr);
            end
        end
        else if (col == COL_ACC)
        begin
            case (row)
                ROW_STX:
                begin
                    cpu_state.acc = cpu_state.xr;
                    update_zn(cpu_state.acc);
                end
                ROW_LDX:
                begin
                    cpu_state.xr = cpu_state.acc;
                    update_zn(cpu_state.xr);
                end
                ROW_DEC:
                begin
                    cpu_state.xr = cpu_state.xr - 8'd1;
                    update_zn(cpu_state.xr);
                end
                ROW_INC: ;
                default: cpu_state.acc = shift_byte(row, cpu_state.acc);
            endcase
        end
        else if (col == COL_IMP)
        begin
            if (row == ROW_STX)
                cpu_state.sp = cpu_state.xr;
            else if (row == ROW_LDX)
            begin
                cpu_state.xr = cpu_state.sp;
                update_zn(cpu_state.xr);
            end
        end
        else
        begin
            case (col)
                COL_ZP:  r.cycle_count = x_or_y_row ? 3'd3 : 3'd5;
                COL_ABS: r.cycle_count = x_or_y_row ? 3'd4 : 3'd6;
                COL_ZPI: r.cycle_count = x_or_y_row ? 3'd4 : 3'd6;
                default: r.cycle_count = x_or_y_row ? 3'd4 + it.page_crossed : 3'd7;
            endcase
            case (row)
                ROW_STX:
                begin
                    r.write_data = (col == COL_ABSI) ?
                                   (cpu_state.xr & (it.addr_high + 8'd1)) : cpu_state.xr;
                    r.write_enable = 1'b1;
                end
                ROW_LDX:
                begin
                    cpu_state.xr = it.mem_data;
                    update_zn(cpu_state.xr);
                end
                ROW_DEC, ROW_INC:
                begin
                    d = (row == ROW_DEC) ? it.mem_data - 8'd1 : it.mem_data + 8'd1;
                    update_zn(d);
                    r.write_data = d;
                    r.write_enable = 1'b1;
                end
                default:
                begin
                    r.write_data = shift_byte(row, it.mem_data);
                    r.write_enable = 1'b1;
                end
            endcase
        end

        r.acc_value     = cpu_state.acc;
        r.xreg_value    = cpu_state.xr;
        r.stack_value   = cpu_state.sp;
        r.carry_flag    = cpu_state.c;
        r.zero_flag     = cpu_state.z;
        r.negative_flag = cpu_state.n;
        return r;
    endfunction

    // ------------------------------------------------------------------
    // Sender side
    // ------------------------------------------------------------------

    // Offer one instruction beat; predict its result once it is accepted
    task automatic send_instr(input in_item_t it);
        int gap;
        gap = src_idle ? $urandom_range(0, 7) : 0;
        if (gap > 0)
        begin
            in_ch.valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_ch.payload <= it;
        in_ch.valid   <= 1'b1;
        // Hold the beat until the block takes it
        @(posedge clk);
        while (!in_ch.ready)
            @(posedge clk);
        expected_results.push_back(execute_group2(it));
        instr_sent++;
        @(negedge clk);
    endtask

    // Build an opcode from its row and column names and send it
    task automatic send_op(input row_t row, input col_t col, input logic [7:0] mem,
                           input logic [7:0] ahi = 8'h00, input logic page = 1'b0,
                           input logic [1:0] low = GROUP2_LOW);
        in_item_t it;
        it.opcode       = {row, col, low};
        it.mem_data     = mem;
        it.addr_high    = ahi;
        it.page_crossed = page;
        send_instr(it);
    endtask

    // Bias data bytes toward the values where flags and wraps change
    function automatic logic [7:0] draw_byte();
        case ($urandom_range(0, 9))
            0:       return 8'h00;
            1:       return 8'hFF;
            2:       return 8'h80;
            3:       return 8'h7F;
            4:       return 8'h01;
            default: return 8'($urandom);
        endcase
    endfunction

    function automatic in_item_t draw_instruction();
        in_item_t it;
        // Mostly clean group opcodes, some with stray low bits
        if ($urandom_range(0, 7) == 0)
            it.opcode = 8'($urandom);
        else
            it.opcode = {3'($urandom), 3'($urandom), GROUP2_LOW};
        it.mem_data     = draw_byte();
        it.addr_high    = draw_byte();
        it.page_crossed = 1'($urandom);
        return it;
    endfunction

    // ------------------------------------------------------------------
    // Receiver side
    // ------------------------------------------------------------------

    initial
    begin : result_sink
        int gap;
        out_ch.ready = 1'b0;
        @(posedge rst_n);
        @(negedge clk);
        forever
        begin
            // Honor a long hold-off request, counted here in cycles
            if (hold_off_cycles > 0)
            begin
                out_ch.ready <= 1'b0;
                repeat (hold_off_cycles) @(negedge clk);
                hold_off_cycles = 0;
            end
            gap = snk_idle ? $urandom_range(0, 7) : 0;
            if (gap > 0)
            begin
                out_ch.ready <= 1'b0;
                repeat (gap) @(negedge clk);
            end
            out_ch.ready <= 1'b1;
            // Keep ready up until a result beat goes through
            @(posedge clk);
            while (!out_ch.valid)
                @(posedge clk);
            @(negedge clk);
        end
    end

    // ------------------------------------------------------------------
    // Checking
    // ------------------------------------------------------------------

    task automatic report_mismatch(input string msg);
        mismatch_count++;
        if (mismatch_count <= MAX_REPORTS)
            $display("MISMATCH at %0t ns, result %0d: %s", $realtime, results_checked, msg);
    endtask

    task automatic check_field(input string name, input int got, input int want);
        if (got != want)
            report_mismatch($sformatf("%s got 0x%0h, expected 0x%0h", name, got, want));
    endtask

    always @(posedge clk)
    begin : result_check
        out_item_t got;
        out_item_t want;
        if (rst_n && out_ch.valid && out_ch.ready)
        begin
            got = out_ch.payload;
            if (expected_results.size() == 0)
                report_mismatch("result beat with no instruction outstanding");
            else
            begin
                want = expected_results.pop_front();
                check_field("write_enable",  got.write_enable,  want.write_enable);
                check_field("write_data",    got.write_data,    want.write_data);
                check_field("cycle_count",   got.cycle_count,   want.cycle_count);
                check_field("halted",        got.halted,        want.halted);
                check_field("acc_value",     got.acc_value,     want.acc_value);
                check_field("xreg_value",    got.xreg_value,    want.xreg_value);
                check_field("stack_value",   got.stack_value,   want.stack_value);
                check_field("carry_flag",    got.carry_flag,    want.carry_flag);
                check_field("zero_flag",     got.zero_flag,     want.zero_flag);
                check_field("negative_flag", got.negative_flag, want.negative_flag);
                jam_results   += want.halted;
                write_results += want.write_enable;
            end
            results_checked++;
        end
    end

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Jam opcodes: halt flag set, state untouched, next instruction runs normally
    task automatic test_jam_opcodes();
        send_op(ROW_ASL, COL_IMM, 8'h5A);
        send_op(ROW_ASL, COL_JAM, 8'hFF);
        send_op(ROW_INC, COL_JAM, 8'h00, 8'hFF, 1'b1);
    endtask

    // LDX immediate, TXA, TXS, TSX, TAX, DEX with wrap, and both kinds of NOP
    task automatic test_register_transfers();
        send_op(ROW_LDX, COL_IMM, 8'h80);   // X = 80, N set
        send_op(ROW_STX, COL_ACC, 8'h00);   // TXA
        send_op(ROW_STX, COL_IMP, 8'h00);   // TXS
        send_op(ROW_LDX, COL_IMM, 8'h00);   // X = 0, Z set
        send_op(ROW_DEC, COL_ACC, 8'h00);   // DEX wraps to FF
        send_op(ROW_LDX, COL_IMP, 8'h00);   // TSX
        send_op(ROW_LDX, COL_ACC, 8'h00);   // TAX
        send_op(ROW_INC, COL_ACC, 8'hFF);   // implied NOP
        send_op(ROW_STX, COL_IMM, 8'hFF);   // immediate NOP
    endtask

    // Accumulator shifts and rotates with the carry going in both ways (A = 80 here)
    task automatic test_accumulator_shifts();
        send_op(ROW_ASL, COL_ACC, 8'h00);
        send_op(ROW_ROL, COL_ACC, 8'h00);
        send_op(ROW_LSR, COL_ACC, 8'h00);
        send_op(ROW_ROR, COL_ACC, 8'h00);
    endtask

    // Read-modify-write on memory, including DEC and INC wrapping
    task automatic test_memory_rmw();
        send_op(ROW_ASL, COL_ZP,   8'h80);
        send_op(ROW_ROR, COL_ABSI, 8'h01);
        send_op(ROW_DEC, COL_ZP,   8'h00);
        send_op(ROW_INC, COL_ABS,  8'hFF);
    endtask

    // STX, SHX with the high byte wrapping, LDX indexed by Y with and without a page cross
    task automatic test_store_and_load();
        send_op(ROW_STX, COL_ZP,   8'h00);
        send_op(ROW_STX, COL_ABSI, 8'h00, 8'hFF, 1'b1);
        send_op(ROW_LDX, COL_ABSI, 8'h7F, 8'h12, 1'b1);
        send_op(ROW_LDX, COL_ZPI,  8'hFF, 8'hFF, 1'b0);
    endtask

    // Low opcode bits other than the group code decode as if they were the group code
    task automatic test_stray_low_bits();
        send_op(ROW_ASL, COL_ACC,  8'h00, 8'h00, 1'b0, 2'b11);
        send_op(ROW_LDX, COL_IMM,  8'hC3, 8'h00, 1'b0, 2'b01);
        send_op(ROW_INC, COL_ABSI, 8'h7F, 8'hFF, 1'b1, 2'b00);
    endtask

    // Hold the output off while the sender keeps offering beats back to back
    task automatic test_output_backpressure();
        src_idle = 1'b0;
        hold_off_cycles = HOLD_OFF;
        repeat (24)
            send_instr(draw_instruction());
    endtask

    // Random instruction stream in phases with different idling on each side
    task automatic test_random_program();
        for (int phase = 0; phase < 13; phase++)
        begin
            // First phase runs at full rate; later ones pick their own mix
            src_idle = (phase == 0) ? 1'b0 : 1'($urandom);
            snk_idle = (phase == 0) ? 1'b0 : 1'($urandom);
            repeat (50)
                send_instr(draw_instruction());
        end
    endtask

    // ------------------------------------------------------------------
    // Run
    // ------------------------------------------------------------------

    initial
    begin : run
        rst_n           = 1'b0;
        in_ch.valid     = 1'b0;
        in_ch.payload   = '0;
        cpu_state       = '0;
        src_idle        = 1'b1;
        snk_idle        = 1'b1;
        hold_off_cycles = 0;
        mismatch_count  = 0;
        instr_sent      = 0;
        results_checked = 0;
        jam_results     = 0;
        write_results   = 0;

        repeat (8) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        test_jam_opcodes();
        test_register_transfers();
        test_accumulator_shifts();
        test_memory_rmw();
        test_store_and_load();
        test_stray_low_bits();
        test_output_backpressure();
        test_random_program();
        in_ch.valid <= 1'b0;

        // Drain the pipeline, then give stray beats a chance to show up
        while (expected_results.size() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);

        $display("Ran %0d instructions (%0d jams, %0d memory writes) over all rows and columns",
                 instr_sent, jam_results, write_results);
        $display("Both sides idled at random; one %0d-cycle output hold-off; %0d bad fields",
                 HOLD_OFF, mismatch_count);
        if (mismatch_count == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

    // Stop a hung run; the timeout lies far beyond the slowest correct run
    initial
    begin : watchdog
        #2000000;
        $display("Timed out with %0d results still owed", expected_results.size());
        $display("FAILURE");
        $finish;
    end

endmodule

@@ cpu6502_group2_execute_top.f @@
src/c6502g2_pkg.sv
src/c6502g2_stream_if.sv
src/c6502g2_exec.sv
src/cpu6502_group2_execute_top.sv
sim/testbench.sv
